### hw/rtl/flk_pkg.sv
package flk_pkg;

    localparam int MAX_REQUESTERS = 8;
    localparam int REQ_W          = $clog2(MAX_REQUESTERS);
    localparam int LVL_W          = 4;
    localparam int TC_W           = 4;

    typedef logic signed [LVL_W-1:0] t_level;
    typedef logic [REQ_W-1:0]        t_req;
    typedef logic [TC_W-1:0]         t_count;

    localparam t_level IDLE_LEVEL = -4'sd1;
    localparam t_level NO_VICTIM  = -4'sd1;

    localparam logic ACT_STEP    = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam t_count TC_MIN   = 4'd2;
    localparam t_count TC_MAX   = 4'd8;
    localparam t_count TC_RESET = 4'd8;

    typedef struct packed {
        logic load;
        logic commit;
    } t_cmd;

endpackage

### hw/rtl/flk_if.sv
interface flk_event_if;
    import flk_pkg::*;
    logic valid;
    logic ready;
    logic action;
    t_req requester;
    modport source (output valid, output action, output requester, input ready);
    modport sink   (input valid, input action, input requester, output ready);
endinterface

interface flk_result_if;
    import flk_pkg::*;
    logic   valid;
    logic   ready;
    t_req   who;
    logic   granted;
    logic   blocked;
    t_level cur_level;
    logic   rejected;
    modport source (output valid, output who, output granted, output blocked,
                    output cur_level, output rejected, input ready);
    modport sink   (input valid, input who, input granted, input blocked,
                    input cur_level, input rejected, output ready);
endinterface

interface flk_cfg_if;
    import flk_pkg::*;
    logic   valid;
    logic   ready;
    t_count data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/filter_lock_arbiter_unit.sv
// Filter lock arbiter: one result transaction per event transaction.
// The event is captured on acceptance, evaluated in S_EVAL, and the result
// registered on commit; no new event is accepted until that commit, and
// the evaluate state waits while the output register still holds a result.
// Reset (synchronous, active low): all requesters idle, no victims, nobody in
// the section, thread_count 8; the block accepts events in the next cycle.
module filter_lock_arbiter_unit
    import flk_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    flk_event_if.sink    i_event,
    flk_cfg_if.sink      i_cfg,
    flk_result_if.source o_result
);

    t_cmd cmd;

    // Configuration writes land in the count register, clamped to 2..8. The user
    // must write only while the block is idle; not enforced, as ready is always high.
    assign i_cfg.ready = 1'b1;

    // Sequence each event: accept, evaluate against the level table, commit
    // state and the result register together.
    flk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_event.valid),
        .o_in_ready  (i_event.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd)
    );

    // Hold levels, victims and section flags; run the victim conflict check
    // as a parallel compare over all requesters below the thread count.
    flk_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_action    (i_event.action),
        .i_requester (i_event.requester),
        .i_cfg_write (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_who       (o_result.who),
        .o_granted   (o_result.granted),
        .o_blocked   (o_result.blocked),
        .o_cur_level (o_result.cur_level),
        .o_rejected  (o_result.rejected)
    );

endmodule

### hw/rtl/flk_ctrl.sv
module flk_ctrl
    import flk_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EVAL
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.commit = (r_state == S_EVAL) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (o_cmd.commit) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && o_cmd.commit))
        else $error("load and commit in the same cycle");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_out_valid)
        else $error("committed result not presented");

    a_load_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> !o_in_ready)
        else $error("input accepted while an event is in evaluation");

endmodule

### hw/rtl/flk_datapath.sv
module flk_datapath
    import flk_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    input  logic   i_action,
    input  t_req   i_requester,
    input  logic   i_cfg_write,
    input  t_count i_cfg_data,
    output t_req   o_who,
    output logic   o_granted,
    output logic   o_blocked,
    output t_level o_cur_level,
    output logic   o_rejected
);

    t_level r_req_level    [MAX_REQUESTERS];
    t_level r_level_victim [MAX_REQUESTERS];
    logic [MAX_REQUESTERS-1:0] r_in_section;
    t_count r_thread_count;

    logic   r_action;
    t_req   r_who;

    t_req   r_out_who;
    logic   r_out_granted;
    logic   r_out_blocked;
    t_level r_out_level;
    logic   r_out_rejected;

    logic   rejected;
    t_level cur;
    t_level top;
    logic   in_sec;
    logic   victim_match;
    logic   other_high;
    logic   conflict;
    logic   climb;
    t_req   cur_idx;
    t_req   next_idx;
    t_level n_level;
    logic   n_granted;
    logic   n_blocked;

    assign rejected     = ({1'b0, r_who} >= r_thread_count);
    assign cur          = r_req_level[r_who];
    assign in_sec       = r_in_section[r_who];
    assign top          = t_level'(r_thread_count - 4'd2);
    assign cur_idx      = cur[REQ_W-1:0];
    assign next_idx     = REQ_W'(cur_idx + 1'b1);
    assign victim_match = (r_level_victim[cur_idx] == t_level'({1'b0, r_who}));
    assign conflict     = !cur[LVL_W-1] && victim_match && other_high;
    assign climb        = (cur < top);

    always_comb begin
        other_high = 1'b0;
        for (int i = 0; i < MAX_REQUESTERS; i++) begin
            if ((TC_W'(i) < r_thread_count) && (REQ_W'(i) != r_who) &&
                (r_req_level[i] >= cur)) begin
                other_high = 1'b1;
            end
        end
    end

    always_comb begin
        n_level   = IDLE_LEVEL;
        n_granted = 1'b0;
        n_blocked = 1'b0;
        priority if (rejected) begin
            n_level = IDLE_LEVEL;
        end else if (r_action == ACT_RELEASE) begin
            n_level = IDLE_LEVEL;
        end else if (in_sec) begin
            n_granted = 1'b1;
            n_level   = cur;
        end else if (cur[LVL_W-1]) begin
            n_level = '0;
        end else if (conflict) begin
            n_blocked = 1'b1;
            n_level   = cur;
        end else if (climb) begin
            n_level = t_level'(cur + 4'sd1);
        end else begin
            n_granted = 1'b1;
            n_level   = cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_REQUESTERS; i++) begin
                r_req_level[i]    <= IDLE_LEVEL;
                r_level_victim[i] <= NO_VICTIM;
            end
            r_in_section   <= '0;
            r_thread_count <= TC_RESET;
        end else begin
            if (i_cfg_write) begin
                priority if (i_cfg_data < TC_MIN) begin
                    r_thread_count <= TC_MIN;
                end else if (i_cfg_data > TC_MAX) begin
                    r_thread_count <= TC_MAX;
                end else begin
                    r_thread_count <= i_cfg_data;
                end
            end
            if (i_cmd.commit && !rejected) begin
                priority if (r_action == ACT_RELEASE) begin
                    r_req_level[r_who]  <= IDLE_LEVEL;
                    r_in_section[r_who] <= 1'b0;
                end else if (in_sec) begin
                    r_in_section[r_who] <= 1'b1;
                end else if (cur[LVL_W-1]) begin
                    r_req_level[r_who] <= '0;
                    r_level_victim[0]  <= t_level'({1'b0, r_who});
                end else if (conflict) begin
                    r_req_level[r_who] <= cur;
                end else if (climb) begin
                    r_req_level[r_who]       <= t_level'(cur + 4'sd1);
                    r_level_victim[next_idx] <= t_level'({1'b0, r_who});
                end else begin
                    r_in_section[r_who] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_who    <= i_requester;
        end
        if (i_cmd.commit) begin
            r_out_who      <= r_who;
            r_out_granted  <= n_granted;
            r_out_blocked  <= n_blocked;
            r_out_level    <= n_level;
            r_out_rejected <= rejected;
        end
    end

    assign o_who       = r_out_who;
    assign o_granted   = r_out_granted;
    assign o_blocked   = r_out_blocked;
    assign o_cur_level = r_out_level;
    assign o_rejected  = r_out_rejected;

endmodule

### verif/lock_grant_checker.sv
`timescale 1ns / 1ps

module lock_grant_checker
    import flk_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    flk_event_if         i_event,
    flk_cfg_if           i_cfg,
    flk_result_if        i_result,
    output int           o_errors,
    output int           o_pending,
    output int           o_grants,
    output int           o_blocks,
    output int           o_rejects
);

    typedef struct packed {
        t_req   who;
        logic   granted;
        logic   blocked;
        t_level cur_level;
        logic   rejected;
    } t_outcome;

    t_level   rung   [MAX_REQUESTERS];
    t_level   victim [MAX_REQUESTERS];
    bit       holding[MAX_REQUESTERS];
    t_count   members;
    t_outcome outcome_q[$];
    int       reported;

    // Advance the lock state by one event and return the outcome it must produce.
    function automatic t_outcome step_lock(input logic act, input t_req who);
        t_outcome r;
        int       lvl;
        int       top;
        bit       clash;
        r           = '0;
        r.who       = who;
        r.cur_level = IDLE_LEVEL;
        top         = int'(members) - 2;
        if (int'(who) >= int'(members)) begin
            r.rejected = 1'b1;
        end else if (act == ACT_RELEASE) begin
            rung[who]    = IDLE_LEVEL;
            holding[who] = 1'b0;
        end else if (holding[who]) begin
            r.granted   = 1'b1;
            r.cur_level = rung[who];
        end else if (rung[who] < 0) begin
            rung[who]   = 4'sd0;
            victim[0]   = t_level'(who);
            r.cur_level = 4'sd0;
        end else begin
            lvl   = int'(rung[who]);
            clash = 1'b0;
            if (int'(victim[lvl]) == int'(who)) begin
                for (int i = 0; i < int'(members); i++) begin
                    if (i != int'(who) && int'(rung[i]) >= lvl)
                        clash = 1'b1;
                end
            end
            if (clash) begin
                r.blocked = 1'b1;
            end else if (lvl < top && lvl + 1 < MAX_REQUESTERS) begin
                lvl         = lvl + 1;
                rung[who]   = t_level'(lvl);
                victim[lvl] = t_level'(who);
            end else begin
                holding[who] = 1'b1;
                r.granted    = 1'b1;
            end
            r.cur_level = t_level'(lvl);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        t_count   v;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_REQUESTERS; i++) begin
                rung[i]    = IDLE_LEVEL;
                victim[i]  = NO_VICTIM;
                holding[i] = 1'b0;
            end
            members = TC_RESET;
            outcome_q.delete();
            o_errors  = 0;
            o_grants  = 0;
            o_blocks  = 0;
            o_rejects = 0;
            reported  = 0;
        end else begin
            if (i_result.valid && i_result.ready) begin
                got = {i_result.who, i_result.granted, i_result.blocked,
                       i_result.cur_level, i_result.rejected};
                if (outcome_q.size() == 0) begin
                    o_errors++;
                    if (reported < 10) begin
                        reported++;
                        $display("%0t: result transaction with nothing outstanding",
                                 $realtime);
                    end
                end else begin
                    want = outcome_q.pop_front();
                    if (got.who !== want.who || got.granted !== want.granted ||
                        got.blocked !== want.blocked || got.cur_level !== want.cur_level ||
                        got.rejected !== want.rejected) begin
                        o_errors++;
                        if (reported < 10) begin
                            reported++;
                            $display({"%0t: mismatch expected who=%0d granted=%b ",
                                      "blocked=%b level=%0d rejected=%b"},
                                     $realtime, want.who, want.granted, want.blocked,
                                     $signed(want.cur_level), want.rejected);
                            $display({"%0t:            actual who=%0d granted=%b ",
                                      "blocked=%b level=%0d rejected=%b"},
                                     $realtime, got.who, got.granted, got.blocked,
                                     $signed(got.cur_level), got.rejected);
                        end
                    end
                    o_grants  += want.granted;
                    o_blocks  += want.blocked;
                    o_rejects += want.rejected;
                end
            end
            // Saturate the count into its legal range.
            if (i_cfg.valid && i_cfg.ready) begin
                v = i_cfg.data;
                if (v < TC_MIN)
                    v = TC_MIN;
                if (v > TC_MAX)
                    v = TC_MAX;
                members = v;
            end
            if (i_event.valid && i_event.ready)
                outcome_q.insert(outcome_q.size(),
                                 step_lock(i_event.action, i_event.requester));
        end
        o_pending = outcome_q.size();
    end

endmodule

### verif/tb_filter_lock_arbiter_unit.sv
`timescale 1ns / 1ps

module tb_filter_lock_arbiter_unit;
    import flk_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n;

    // Toggle every half period: 10 ns clock.
    always #5 clk = ~clk;

    flk_event_if  ev_if();
    flk_cfg_if    cfg_if();
    flk_result_if res_if();

    filter_lock_arbiter_unit dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_event  (ev_if),
        .i_cfg    (cfg_if),
        .o_result (res_if)
    );

    int errors;
    int pending;
    int grants;
    int blocks;
    int rejects;

    lock_grant_checker u_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_event   (ev_if),
        .i_cfg     (cfg_if),
        .i_result  (res_if),
        .o_errors  (errors),
        .o_pending (pending),
        .o_grants  (grants),
        .o_blocks  (blocks),
        .o_rejects (rejects)
    );

    // Idling knobs, in percent; hold_off freezes the result side completely.
    int idle_pct  = 0;
    int stall_pct = 0;
    bit hold_off  = 1'b0;

    // Requester count as the stimulus sees it, used only to aim the events.
    int lanes     = TC_RESET;
    int n_events  = 0;
    int n_cfg     = 0;
    int cycles    = 0;

    // Watchdog: kill a hung run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: take or refuse a transaction once per cycle, driven at the falling edge.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            res_if.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one event; call at a falling edge, returns at the falling edge after acceptance.
    task automatic push_event(input logic act, input t_req who);
        while ($urandom_range(99) < idle_pct) begin
            ev_if.valid <= 1'b0;
            @(negedge clk);
        end
        ev_if.valid     <= 1'b1;
        ev_if.action    <= act;
        ev_if.requester <= who;
        do @(posedge clk); while (!ev_if.ready);
        n_events++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every outstanding result has been taken.
    task automatic drain();
        ev_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write the requester count; only call with the block drained.
    task automatic write_count(input t_count v);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        lanes = (v < TC_MIN) ? int'(TC_MIN) : (v > TC_MAX) ? int'(TC_MAX) : int'(v);
        n_cfg++;
    endtask

    // Mostly runs of steps by one requester so that it climbs the levels, then a
    // release now and then; a tenth of the picks ignore the count to hit rejects.
    task automatic random_burst(input int count);
        int   done;
        int   run;
        t_req who;
        done = 0;
        while (done < count) begin
            if ($urandom_range(9) == 0)
                who = t_req'($urandom_range(MAX_REQUESTERS - 1));
            else
                who = t_req'($urandom_range(lanes - 1));
            run = $urandom_range(1, 8);
            repeat (run) begin
                push_event(ACT_STEP, who);
                done++;
            end
            if ($urandom_range(99) < 35) begin
                push_event(ACT_RELEASE, who);
                done++;
            end
        end
    endtask

    initial begin
        t_count v;
        int     fails;

        ev_if.valid     = 1'b0;
        ev_if.action    = ACT_STEP;
        ev_if.requester = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.data     = '0;
        rst_n           = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, count 8: release while idle, victim conflict, climb, release while waiting.
        push_event(ACT_RELEASE, 3'd0);
        push_event(ACT_STEP,    3'd7);
        push_event(ACT_STEP,    3'd0);
        push_event(ACT_STEP,    3'd0);
        push_event(ACT_STEP,    3'd7);
        push_event(ACT_STEP,    3'd0);
        push_event(ACT_RELEASE, 3'd7);
        push_event(ACT_STEP,    3'd0);
        drain();

        // Shrink to two while requester 0 stands above the new top level: it gets
        // the section, steps again while holding, and high indexes are rejected.
        write_count(4'd2);
        push_event(ACT_STEP,    3'd0);
        push_event(ACT_STEP,    3'd0);
        push_event(ACT_STEP,    3'd5);
        push_event(ACT_RELEASE, 3'd7);
        push_event(ACT_RELEASE, 3'd0);
        push_event(ACT_RELEASE, 3'd1);
        push_event(ACT_STEP,    3'd1);
        push_event(ACT_STEP,    3'd0);
        push_event(ACT_STEP,    3'd1);
        push_event(ACT_STEP,    3'd0);
        push_event(ACT_RELEASE, 3'd1);
        push_event(ACT_STEP,    3'd0);
        push_event(ACT_STEP,    3'd0);
        drain();

        // Random phases: sweep the count through its extremes and the saturating
        // values, rotate the idling pattern, and stall the result side hard once.
        for (int p = 0; p < 12; p++) begin
            case (p)
                0:       v = 4'd0;
                1:       v = 4'd15;
                2:       v = 4'd8;
                3:       v = 4'd1;
                4:       v = 4'd9;
                5:       v = 4'd2;
                default: v = t_count'($urandom_range(3, 8));
            endcase
            write_count(v);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 57; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 57; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            if (p == 2) begin
                // Hold results off while events keep coming so the block backs up.
                fork
                    begin
                        @(posedge clk);
                        hold_off = 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            random_burst(42);
            drain();
        end

        idle_pct  = 0;
        stall_pct = 0;
        ev_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Ran %0d events across %0d count writes, count swept from 2 to 8 with saturation.",
                 n_events, n_cfg);
        $display("Saw %0d grants, %0d blocked steps and %0d rejected events.",
                 grants, blocks, rejects);
        fails = errors + pending;
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
